FILE: hw/rtl/swam_pkg.sv
// ---------------------------------------------------------------------------
// swam_pkg
// Shared types and constants for the sliding window anagram matcher.
// ---------------------------------------------------------------------------
package swam_pkg;

    localparam int ALPHA_SIZE  = 26;
    localparam int LETTER_W    = 5;
    localparam int ACTION_W    = 2;
    localparam int MAX_PATTERN = 1024;
    localparam int CNT_W       = $clog2(MAX_PATTERN + 1);
    localparam int RING_AW     = $clog2(MAX_PATTERN);
    localparam int POS_W       = 32;
    localparam int IN_DATA_W   = 8;
    localparam int IN_USER_W   = 8;
    localparam int OUT_DATA_W  = 40;

    typedef enum logic [ACTION_W-1:0] {
        ACT_CLEAR   = 2'd0,
        ACT_PATTERN = 2'd1,
        ACT_RESTART = 2'd2,
        ACT_TEXT    = 2'd3
    } action_t;

    // one item travelling down the cell chain
    typedef struct packed {
        logic                valid;
        action_t             act;
        logic [LETTER_W-1:0] letter;
        logic [LETTER_W-1:0] drop_letter;
        logic                drop_valid;
        logic                upd;        // text item touches the counts
        logic                ok;         // window full and all cells so far agree
        logic [POS_W-1:0]    start;
        logic                ovf;
    } item_t;

endpackage

FILE: hw/rtl/sliding_window_anagram_matcher.sv
// ---------------------------------------------------------------------------
// sliding_window_anagram_matcher
// Streams letters; reports per text letter whether the last window of pattern
// length is an anagram of the pattern.
// ---------------------------------------------------------------------------
// Use:
//   Slave side carries one item per letter: s_tuser holds the action (clear,
//   pattern letter, restart text, text letter), s_tdata the letter index.
//   Every text letter gives one result item on the master side: match, the
//   window's start index (mod 2^32) and the sticky pattern overflow flag.
//   Other actions give no result.
// Stages from accept to result: one front stage holding the window
//   bookkeeping and ring read, then one stage per letter cell, 26.
// Throughput: one item per cycle while m_tready is high; every stage owns
//   its counts and hands the item on each cycle, the ring takes one write
//   and one read per item.
// Stall: the whole chain holds while a result waits unaccepted at the end;
//   s_tready falls with it. Items that give no result never block.
// Reset: all counts, lengths, position and overflow flag clear at once; the
//   ring of window letters needs no clearing, only entries written since the
//   last restart are read.
// ---------------------------------------------------------------------------
module sliding_window_anagram_matcher (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [swam_pkg::IN_DATA_W-1:0]    s_tdata,   // [4:0] letter
    input  logic [swam_pkg::IN_USER_W-1:0]    s_tuser,   // [1:0] action
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [swam_pkg::OUT_DATA_W-1:0]   m_tdata    // [0] match, [32:1] start_index,
                                                         // [33] pattern_overflow
);
    import swam_pkg::*;

    logic    advance;
    item_t   chain [ALPHA_SIZE+1];
    item_t   last;

    // global step: the chain moves unless a result sits unaccepted at its end
    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;

    swam_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_valid (s_tvalid),
        .action   (action_t'(s_tuser[ACTION_W-1:0])),
        .letter   (s_tdata[LETTER_W-1:0]),
        .item     (chain[0])
    );

    for (genvar i = 0; i < ALPHA_SIZE; i++)
    begin : g_cell
        swam_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .cell_id  (LETTER_W'(i)),
            .item_in  (chain[i]),
            .item_out (chain[i+1])
        );
    end

    assign last     = chain[ALPHA_SIZE];
    assign m_tvalid = last.valid && (last.act == ACT_TEXT);
    assign m_tdata  = {6'd0, last.ovf, last.start, last.ok};

endmodule

FILE: hw/rtl/swam_front.sv
// ---------------------------------------------------------------------------
// swam_front
// Input decode, window bookkeeping and the ring of window letters.
// ---------------------------------------------------------------------------
module swam_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic                          in_valid,
    input  swam_pkg::action_t             action,
    input  logic [swam_pkg::LETTER_W-1:0] letter,
    output swam_pkg::item_t               item
);
    import swam_pkg::*;

    logic [CNT_W-1:0]    plen_reg, plen_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [RING_AW-1:0]  rp_reg, rp_next;
    logic                ovf_reg, ovf_next;
    item_t               item_reg, item_next;

    logic [LETTER_W-1:0] ring_mem [MAX_PATTERN];
    logic [LETTER_W-1:0] rdata_reg;
    logic                ring_we;
    logic [RING_AW-1:0]  rd_idx;
    logic                accept;
    logic                drop;
    logic [CNT_W-1:0]    fill_new;

    assign accept = in_valid && advance;
    assign rd_idx = rp_reg - plen_reg[RING_AW-1:0];
    assign drop   = (fill_reg == plen_reg);
    assign fill_new = drop ? fill_reg : fill_reg + CNT_W'(1);

    always_comb
    begin
        plen_next = plen_reg;
        fill_next = fill_reg;
        pos_next  = pos_reg;
        rp_next   = rp_reg;
        ovf_next  = ovf_reg;
        ring_we   = 1'b0;
        item_next = '0;
        item_next.act    = action;
        item_next.letter = letter;
        if (accept)
        begin
            case (action)
                ACT_CLEAR:
                begin
                    plen_next = '0;
                    fill_next = '0;
                    pos_next  = '0;
                    rp_next   = '0;
                    ovf_next  = 1'b0;
                    item_next.valid = 1'b1;
                end
                ACT_PATTERN:
                begin
                    if (32'(letter) < ALPHA_SIZE)
                    begin
                        if (32'(plen_reg) == MAX_PATTERN)
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            plen_next = plen_reg + CNT_W'(1);
                            fill_next = '0;
                            pos_next  = '0;
                            rp_next   = '0;
                            item_next.valid = 1'b1;
                        end
                    end
                end
                ACT_RESTART:
                begin
                    fill_next = '0;
                    pos_next  = '0;
                    rp_next   = '0;
                    item_next.valid = 1'b1;
                end
                ACT_TEXT:
                begin
                    pos_next = pos_reg + POS_W'(1);
                    item_next.valid = 1'b1;
                    item_next.ovf   = ovf_reg;
                    if (plen_reg == '0)
                    begin
                        item_next.start = pos_reg;
                    end
                    else
                    begin
                        ring_we   = 1'b1;
                        rp_next   = rp_reg + RING_AW'(1);
                        fill_next = fill_new;
                        item_next.upd        = 1'b1;
                        item_next.drop_valid = drop;
                        item_next.ok         = (fill_new == plen_reg);
                        item_next.start      = pos_reg + POS_W'(1) - POS_W'(fill_new);
                    end
                end
                default:
                begin
                    item_next.valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg <= '0;
            fill_reg <= '0;
            pos_reg  <= '0;
            rp_reg   <= '0;
            ovf_reg  <= 1'b0;
            item_reg <= '0;
        end
        else if (advance)
        begin
            plen_reg <= plen_next;
            fill_reg <= fill_next;
            pos_reg  <= pos_next;
            rp_reg   <= rp_next;
            ovf_reg  <= ovf_next;
            item_reg <= item_next;
        end
    end

    // ring: read of the oldest letter sees the old entry when it shares the address
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rdata_reg <= ring_mem[rd_idx];
        end
        if (ring_we)
        begin
            ring_mem[rp_reg] <= letter;
        end
    end

    always_comb
    begin
        item = item_reg;
        item.drop_letter = rdata_reg;
    end

endmodule

FILE: hw/rtl/swam_cell.sv
// ---------------------------------------------------------------------------
// swam_cell
// One letter of the alphabet: pattern and window counts, one chain stage.
// ---------------------------------------------------------------------------
module swam_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic [swam_pkg::LETTER_W-1:0] cell_id,
    input  swam_pkg::item_t               item_in,
    output swam_pkg::item_t               item_out
);
    import swam_pkg::*;

    logic [CNT_W-1:0] pcnt_reg, pcnt_next;
    logic [CNT_W-1:0] wcnt_reg, wcnt_next;
    item_t            item_reg, item_next;
    logic             inc, dec;

    assign inc = (item_in.letter == cell_id);
    assign dec = item_in.drop_valid && (item_in.drop_letter == cell_id) && (wcnt_reg != '0);

    always_comb
    begin
        pcnt_next = pcnt_reg;
        wcnt_next = wcnt_reg;
        item_next = item_in;
        if (item_in.valid)
        begin
            case (item_in.act)
                ACT_CLEAR:
                begin
                    pcnt_next = '0;
                    wcnt_next = '0;
                end
                ACT_PATTERN:
                begin
                    if (inc)
                    begin
                        pcnt_next = pcnt_reg + CNT_W'(1);
                    end
                    wcnt_next = '0;
                end
                ACT_RESTART:
                begin
                    wcnt_next = '0;
                end
                ACT_TEXT:
                begin
                    if (item_in.upd)
                    begin
                        wcnt_next = wcnt_reg + CNT_W'(inc) - CNT_W'(dec);
                    end
                    item_next.ok = item_in.ok && ((pcnt_reg == '0) || (wcnt_next == pcnt_reg));
                end
                default:
                begin
                    wcnt_next = wcnt_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcnt_reg <= '0;
            wcnt_reg <= '0;
            item_reg <= '0;
        end
        else if (advance)
        begin
            pcnt_reg <= pcnt_next;
            wcnt_reg <= wcnt_next;
            item_reg <= item_next;
        end
    end

    assign item_out = item_reg;

endmodule
